>>> rtl/core/swfrect_pkg.sv
package swfrect_pkg;

  localparam int unsigned SCAN_W        = 31;
  localparam int unsigned SCAN_LIMIT    = SCAN_W - 1;
  localparam int unsigned MAX_MOVE_BITS = 31;
  localparam int unsigned HDR_BYTES     = 14;
  localparam int unsigned EDGES         = 4;

  typedef struct packed {
    logic       byte_vld;
    logic [7:0] byte_dat;
    logic       byte_last;
    logic       bit_vld;
    logic       bit_dat;
    logic       bit_fin;
  } pk_cmd_t;

endpackage

>>> rtl/core/swfrect_width_scan.sv
module swfrect_width_scan import swfrect_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [SCAN_W-1:0] val_i,
  output logic [4:0]        width_o,
  output logic              done_o
);

  logic [SCAN_W-1:0] sh_q, sh_d;
  logic [4:0]        k_q, k_d;
  logic              run_q, run_d;

  always_comb begin
    sh_d  = sh_q;
    k_d   = k_q;
    run_d = run_q;
    if (load_i) begin
      sh_d  = val_i;
      k_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh_q[SCAN_W-1] == sh_q[SCAN_W-2]) begin
        sh_d = {sh_q[SCAN_W-1], sh_q[SCAN_W-3:0], 1'b0};
        k_d  = k_q + 5'd1;
        if (k_q == 5'(SCAN_LIMIT - 1)) begin
          run_d = 1'b0;
        end
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    k_q  <= k_d;
  end

  assign width_o = 5'(SCAN_W) - k_q;
  assign done_o  = ~run_q;

endmodule

>>> rtl/core/swfrect_bit_packer.sv
module swfrect_bit_packer import swfrect_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pk_cmd_t    cmd_i,
  output logic       flush_o,
  output logic       out_valid_o,
  output logic [7:0] byte_out_o,
  output logic       last_byte_o
);

  logic [7:0] acc_q, acc_d;
  logic [2:0] nb_q, nb_d;
  logic       flush_q, flush_d;
  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       ol_q, ol_d;
  logic       push, bit_in;

  always_comb begin
    push    = cmd_i.bit_vld | flush_q;
    bit_in  = cmd_i.bit_dat & ~flush_q;
    acc_d   = acc_q;
    nb_d    = nb_q;
    flush_d = flush_q;
    ov_d    = 1'b0;
    ob_d    = ob_q;
    ol_d    = ol_q;
    if (cmd_i.byte_vld) begin
      ov_d = 1'b1;
      ob_d = cmd_i.byte_dat;
      ol_d = cmd_i.byte_last;
    end
    if (push) begin
      acc_d = {acc_q[6:0], bit_in};
      nb_d  = nb_q + 3'd1;
      if (nb_q == 3'd7) begin
        ov_d    = 1'b1;
        ob_d    = acc_d;
        ol_d    = flush_q | cmd_i.bit_fin;
        flush_d = 1'b0;
      end else if (cmd_i.bit_fin) begin
        flush_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q    <= '0;
      flush_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      nb_q    <= nb_d;
      flush_q <= flush_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign flush_o     = flush_q;
  assign out_valid_o = ov_q;
  assign byte_out_o  = ob_q;
  assign last_byte_o = ol_q;

  a_no_push_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !cmd_i.bit_vld)
    else $error("bit pushed while padding");

  a_byte_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.byte_vld |-> (!cmd_i.bit_vld && !flush_q && nb_q == 3'd0))
    else $error("byte word collides with bit packing");

  a_flush_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> nb_q != 3'd0)
    else $error("padding with an empty accumulator");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |=> !ov_q)
    else $error("word right after last word");

endmodule

>>> rtl/core/swf_rect_shape_record_encoder.sv
// Encodes one rectangle into its shape-with-style byte stream. An item is taken
// when start is high and busy is low; busy stays high until the last word has
// been handed over. Words appear on byte_out_o/last_byte_o for exactly one cycle
// with out_valid_o high and cannot be held off by the receiver. The 14 style
// bytes leave one per cycle; the record bits are then packed one per cycle into
// eight-bit words. The record is 61 to 181 bits long and is padded with 0 to 7
// zero bits to a whole word; the 31-bit sign-run scanners size its fields, and
// the bits are packed only once every scanner is done.
module swf_rect_shape_record_encoder import swfrect_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] fill_color_i,
  input  logic [15:0] line_width_i,
  input  logic [31:0] line_color_i,
  input  logic [30:0] x_origin_i,
  input  logic [30:0] y_origin_i,
  input  logic [16:0] rect_width_i,
  input  logic [16:0] rect_height_i,
  output logic        out_valid_o,
  output logic [7:0]  byte_out_o,
  output logic        last_byte_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HDR   = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_BITS  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  localparam logic [3:0] F_SCR = 4'd0;
  localparam logic [3:0] F_MB  = 4'd1;
  localparam logic [3:0] F_MX  = 4'd2;
  localparam logic [3:0] F_MY  = 4'd3;
  localparam logic [3:0] F_STY = 4'd4;
  localparam logic [3:0] F_EH0 = 4'd5;
  localparam logic [3:0] F_ED0 = 4'd6;
  localparam logic [3:0] F_EH1 = 4'd7;
  localparam logic [3:0] F_ED1 = 4'd8;
  localparam logic [3:0] F_EH2 = 4'd9;
  localparam logic [3:0] F_ED2 = 4'd10;
  localparam logic [3:0] F_EH3 = 4'd11;
  localparam logic [3:0] F_ED3 = 4'd12;
  localparam logic [3:0] F_END = 4'd13;

  localparam logic [5:0] SCR_FLAGS = 6'b001011;
  localparam logic [1:0] STY_SEL   = 2'b11;
  localparam logic [1:0] EDGE_TAG  = 2'b11;
  localparam logic [7:0] NBITS_HDR = 8'h11;
  localparam logic [7:0] STYLE_CNT = 8'h01;
  localparam logic [7:0] FILL_SOL  = 8'h00;
  localparam logic [4:0] SCR_LEN   = 5'd6;
  localparam logic [4:0] MB_LEN    = 5'd5;
  localparam logic [4:0] STY_LEN   = 5'd2;
  localparam logic [4:0] EH_LEN    = 5'd8;
  localparam logic [4:0] END_LEN   = 5'd6;

  state_e state_q, state_d;
  logic [3:0] hidx_q, hidx_d;
  logic [3:0] fld_q, fld_d, fld_nxt;
  logic [4:0] bidx_q, bidx_d;

  logic [31:0] fill_q, lc_q;
  logic [15:0] lw_q;
  logic [30:0] x_q, y_q;
  logic [16:0] d_q [EDGES];
  logic        hnz_q;
  logic        accept;

  logic [16:0] neg_w, neg_h;
  logic [17:0] neg_w_full, neg_h_full;

  logic [SCAN_W-1:0] scan_val [EDGES+2];
  logic [4:0]        scan_w   [EDGES+2];
  logic [EDGES+1:0]  scan_done;

  logic [4:0] mb, mb_raw;
  logic [4:0] n_e   [EDGES];
  logic       vert_e [EDGES];
  logic [30:0] fval;
  logic [4:0]  len_nxt;
  logic [7:0]  hdr_byte;

  pk_cmd_t cmd;
  logic    pk_flush;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  assign neg_w_full = 18'd0 - {rect_width_i[16], rect_width_i};
  assign neg_h_full = 18'd0 - {rect_height_i[16], rect_height_i};
  assign neg_w = (neg_w_full[17:16] == 2'b01) ? 17'h0FFFF : neg_w_full[16:0];
  assign neg_h = (neg_h_full[17:16] == 2'b01) ? 17'h0FFFF : neg_h_full[16:0];

  assign scan_val[0] = x_origin_i;
  assign scan_val[1] = y_origin_i;
  assign scan_val[2] = {{(SCAN_W-17){rect_width_i[16]}}, rect_width_i};
  assign scan_val[3] = {{(SCAN_W-17){rect_height_i[16]}}, rect_height_i};
  assign scan_val[4] = {{(SCAN_W-17){neg_w[16]}}, neg_w};
  assign scan_val[5] = {{(SCAN_W-17){neg_h[16]}}, neg_h};

  for (genvar g = 0; g < EDGES + 2; g++) begin : g_scan
    swfrect_width_scan u_scan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (accept),
      .val_i  (scan_val[g]),
      .width_o(scan_w[g]),
      .done_o (scan_done[g])
    );
  end

  assign mb_raw = (scan_w[0] > scan_w[1]) ? scan_w[0] : scan_w[1];
  assign mb     = (mb_raw > 5'(MAX_MOVE_BITS)) ? 5'(MAX_MOVE_BITS) : mb_raw;

  for (genvar e = 0; e < EDGES; e++) begin : g_edge
    assign n_e[e] = (scan_w[e+2] < 5'd2) ? 5'd2 : scan_w[e+2];
  end
  assign vert_e[0] = 1'b0;
  assign vert_e[1] = hnz_q;
  assign vert_e[2] = 1'b0;
  assign vert_e[3] = hnz_q;

  always_comb begin
    unique case (hidx_q)
      4'd0:    hdr_byte = STYLE_CNT;
      4'd1:    hdr_byte = FILL_SOL;
      4'd2:    hdr_byte = fill_q[31:24];
      4'd3:    hdr_byte = fill_q[23:16];
      4'd4:    hdr_byte = fill_q[15:8];
      4'd5:    hdr_byte = fill_q[7:0];
      4'd6:    hdr_byte = STYLE_CNT;
      4'd7:    hdr_byte = lw_q[7:0];
      4'd8:    hdr_byte = lw_q[15:8];
      4'd9:    hdr_byte = lc_q[31:24];
      4'd10:   hdr_byte = lc_q[23:16];
      4'd11:   hdr_byte = lc_q[15:8];
      4'd12:   hdr_byte = lc_q[7:0];
      4'd13:   hdr_byte = NBITS_HDR;
      default: hdr_byte = '0;
    endcase
  end

  function automatic logic [30:0] edge_hdr(input logic [4:0] n, input logic vert);
    logic [4:0] nm2;
    nm2 = n - 5'd2;
    return {23'd0, EDGE_TAG, nm2[3:0], 1'b0, vert};
  endfunction

  function automatic logic [30:0] edge_val(input logic [16:0] d);
    return {{14{d[16]}}, d};
  endfunction

  always_comb begin
    unique case (fld_q)
      F_SCR:   fval = {25'd0, SCR_FLAGS};
      F_MB:    fval = {26'd0, mb};
      F_MX:    fval = x_q;
      F_MY:    fval = y_q;
      F_STY:   fval = {29'd0, STY_SEL};
      F_EH0:   fval = edge_hdr(n_e[0], vert_e[0]);
      F_ED0:   fval = edge_val(d_q[0]);
      F_EH1:   fval = edge_hdr(n_e[1], vert_e[1]);
      F_ED1:   fval = edge_val(d_q[1]);
      F_EH2:   fval = edge_hdr(n_e[2], vert_e[2]);
      F_ED2:   fval = edge_val(d_q[2]);
      F_EH3:   fval = edge_hdr(n_e[3], vert_e[3]);
      F_ED3:   fval = edge_val(d_q[3]);
      default: fval = '0;
    endcase
  end

  assign fld_nxt = fld_q + 4'd1;

  always_comb begin
    unique case (fld_nxt)
      F_SCR:   len_nxt = SCR_LEN;
      F_MB:    len_nxt = MB_LEN;
      F_MX:    len_nxt = mb;
      F_MY:    len_nxt = mb;
      F_STY:   len_nxt = STY_LEN;
      F_EH0:   len_nxt = EH_LEN;
      F_ED0:   len_nxt = n_e[0];
      F_EH1:   len_nxt = EH_LEN;
      F_ED1:   len_nxt = n_e[1];
      F_EH2:   len_nxt = EH_LEN;
      F_ED2:   len_nxt = n_e[2];
      F_EH3:   len_nxt = EH_LEN;
      F_ED3:   len_nxt = n_e[3];
      F_END:   len_nxt = END_LEN;
      default: len_nxt = 5'd1;
    endcase
  end

  always_comb begin
    state_d = state_q;
    hidx_d  = hidx_q;
    fld_d   = fld_q;
    bidx_d  = bidx_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_HDR;
          hidx_d  = '0;
        end
      end
      ST_HDR: begin
        cmd.byte_vld = 1'b1;
        cmd.byte_dat = hdr_byte;
        hidx_d       = hidx_q + 4'd1;
        if (hidx_q == 4'(HDR_BYTES - 1)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (&scan_done) begin
          state_d = ST_BITS;
          fld_d   = F_SCR;
          bidx_d  = SCR_LEN - 5'd1;
        end
      end
      ST_BITS: begin
        cmd.bit_vld = 1'b1;
        cmd.bit_dat = fval[bidx_q];
        cmd.bit_fin = (fld_q == F_END) && (bidx_q == 5'd0);
        if (bidx_q == 5'd0) begin
          if (fld_q == F_END) begin
            state_d = ST_DRAIN;
          end else begin
            fld_d  = fld_nxt;
            bidx_d = len_nxt - 5'd1;
          end
        end else begin
          bidx_d = bidx_q - 5'd1;
        end
      end
      ST_DRAIN: begin
        if (!pk_flush) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hidx_q  <= '0;
      fld_q   <= F_SCR;
      bidx_q  <= '0;
    end else begin
      state_q <= state_d;
      hidx_q  <= hidx_d;
      fld_q   <= fld_d;
      bidx_q  <= bidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fill_q <= fill_color_i;
      lw_q   <= line_width_i;
      lc_q   <= line_color_i;
      x_q    <= x_origin_i;
      y_q    <= y_origin_i;
      d_q[0] <= rect_width_i;
      d_q[1] <= rect_height_i;
      d_q[2] <= neg_w;
      d_q[3] <= neg_h;
      hnz_q  <= (rect_height_i != 17'd0);
    end
  end

  swfrect_bit_packer u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .flush_o    (pk_flush),
    .out_valid_o(out_valid_o),
    .byte_out_o (byte_out_o),
    .last_byte_o(last_byte_o)
  );

endmodule
